/* sv/qrsd_pkg.sv */
`timescale 1ns / 1ps

package qrsd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_CHAR_COUNT = 2'd1;

    // Segment modes (any other code decodes as byte mode)
    localparam logic [1:0] MODE_NUMERIC = 2'd0;
    localparam logic [1:0] MODE_ALNUM   = 2'd1;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RANGE      = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // How a finished group is to be turned into characters
    typedef enum logic [1:0] {
        GRP_NUMERIC = 2'd0,
        GRP_ALNUM   = 2'd1,
        GRP_BYTE    = 2'd2
    } grp_kind_t;

    typedef struct packed {
        logic data_bit;
        logic end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    // A completed group, as captured from the bit stream
    typedef struct packed {
        grp_kind_t   kind;
        logic [1:0]  nchars;
        logic        last;
        logic [1:0]  status;
        logic [10:0] value;
    } grp_t;

    // A group split into its leading part and remainder
    typedef struct packed {
        grp_kind_t  kind;
        logic [1:0] nchars;
        logic       last;
        logic [1:0] status;
        logic [5:0] hi;
        logic [6:0] rem;
        logic [7:0] raw;
    } split_t;

    // One queue entry: up to three characters, first in element 0
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      nchars;
        logic            last;
        logic [1:0]      status;
    } fifo_ent_t;

    // The 45-symbol alphanumeric character set
    function automatic logic [7:0] alnum_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 6'd10) begin
            c = ASCII_ZERO + {2'b00, idx};
        end
        else if (idx < 6'd36) begin
            c = 8'h41 + ({2'b00, idx} - 8'd10);
        end
        else begin
            case (idx)
                6'd36:   c = 8'h20;
                6'd37:   c = 8'h24;
                6'd38:   c = 8'h25;
                6'd39:   c = 8'h2A;
                6'd40:   c = 8'h2B;
                6'd41:   c = 8'h2D;
                6'd42:   c = 8'h2E;
                6'd43:   c = 8'h2F;
                6'd44:   c = 8'h3A;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

/* sv/qrsd_group.sv */
`timescale 1ns / 1ps

module qrsd_group (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  qrsd_pkg::in_item_t item,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              grp_valid,
    output qrsd_pkg::grp_t    grp
);

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] count_reg, count_next;
    logic [10:0] acc_reg, acc_next;
    logic [3:0]  bits_reg, bits_next;
    logic [15:0] left_reg, left_next;
    logic        done_reg, done_next;
    logic        grp_valid_reg, grp_valid_next;
    qrsd_pkg::grp_t grp_reg, grp_next;

    logic [10:0] acc_shift;
    logic [3:0]  bits_inc;
    logic [3:0]  need;
    logic [1:0]  nchars;
    logic [10:0] limit;
    qrsd_pkg::grp_kind_t kind;
    logic        final_char;

    // Group size and value bound for the current mode and remaining count
    always_comb
    begin
        case (mode_reg)
            qrsd_pkg::MODE_NUMERIC:
            begin
                kind = qrsd_pkg::GRP_NUMERIC;
                if (left_reg >= 16'd3)
                begin
                    need = 4'd10; nchars = 2'd3; limit = 11'd1000;
                end
                else if (left_reg == 16'd2)
                begin
                    need = 4'd7;  nchars = 2'd2; limit = 11'd100;
                end
                else
                begin
                    need = 4'd4;  nchars = 2'd1; limit = 11'd10;
                end
            end
            qrsd_pkg::MODE_ALNUM:
            begin
                kind = qrsd_pkg::GRP_ALNUM;
                if (left_reg >= 16'd2)
                begin
                    need = 4'd11; nchars = 2'd2; limit = 11'd2025;
                end
                else
                begin
                    need = 4'd6;  nchars = 2'd1; limit = 11'd45;
                end
            end
            default:
            begin
                kind = qrsd_pkg::GRP_BYTE;
                need = 4'd8; nchars = 2'd1; limit = 11'd256;
            end
        endcase
    end

    assign acc_shift  = {acc_reg[9:0], item.data_bit};
    assign bits_inc   = bits_reg + 4'd1;
    assign final_char = (left_reg == {14'd0, nchars});

    // Bit collection, group completion and segment bookkeeping
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        bits_next      = bits_reg;
        left_next      = left_reg;
        done_next      = done_reg;
        grp_valid_next = 1'b0;
        grp_next       = grp_reg;

        if (cfg_we && (cfg_index == qrsd_pkg::REG_MODE ||
                       cfg_index == qrsd_pkg::REG_CHAR_COUNT))
        begin
            if (cfg_index == qrsd_pkg::REG_MODE)
            begin
                mode_next = cfg_data[1:0];
                left_next = count_reg;
            end
            else
            begin
                count_next = cfg_data;
                left_next  = cfg_data;
            end
            acc_next  = '0;
            bits_next = '0;
            done_next = 1'b0;
        end
        else if (accept && !done_reg && left_reg != 16'd0)
        begin
            if (bits_inc < need)
            begin
                acc_next  = acc_shift;
                bits_next = bits_inc;
                if (item.end_of_data)
                begin
                    // Data ran out part way through a group
                    done_next       = 1'b1;
                    grp_valid_next  = 1'b1;
                    grp_next.kind   = qrsd_pkg::GRP_BYTE;
                    grp_next.nchars = 2'd1;
                    grp_next.last   = 1'b1;
                    grp_next.status = qrsd_pkg::STATUS_INCOMPLETE;
                    grp_next.value  = '0;
                end
            end
            else
            begin
                acc_next       = '0;
                bits_next      = '0;
                grp_valid_next = 1'b1;
                if (acc_shift >= limit)
                begin
                    done_next       = 1'b1;
                    grp_next.kind   = qrsd_pkg::GRP_BYTE;
                    grp_next.nchars = 2'd1;
                    grp_next.last   = 1'b1;
                    grp_next.status = qrsd_pkg::STATUS_RANGE;
                    grp_next.value  = '0;
                end
                else
                begin
                    left_next       = left_reg - {14'd0, nchars};
                    done_next       = final_char || item.end_of_data;
                    grp_next.kind   = kind;
                    grp_next.nchars = nchars;
                    grp_next.last   = final_char || item.end_of_data;
                    grp_next.status = (!final_char && item.end_of_data) ?
                                      qrsd_pkg::STATUS_INCOMPLETE : qrsd_pkg::STATUS_OK;
                    grp_next.value  = acc_shift;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= qrsd_pkg::MODE_NUMERIC;
            count_reg     <= '0;
            acc_reg       <= '0;
            bits_reg      <= '0;
            left_reg      <= '0;
            done_reg      <= 1'b0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            bits_reg      <= bits_next;
            left_reg      <= left_next;
            done_reg      <= done_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign grp_valid = grp_valid_reg;
    assign grp       = grp_reg;

endmodule

/* sv/qrsd_convert.sv */
`timescale 1ns / 1ps

module qrsd_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                grp_valid,
    input  qrsd_pkg::grp_t      grp,
    output logic                split_valid,
    output logic                ent_valid,
    output qrsd_pkg::fifo_ent_t ent
);

    logic [15:0] prod_num;
    logic [3:0]  hi_num;
    logic [9:0]  rem_num;
    logic [21:0] prod_al;
    logic [5:0]  hi_al;
    logic [10:0] rem_al;

    qrsd_pkg::split_t split_reg, split_next;
    logic             split_valid_reg;

    logic [14:0] prod_tens;
    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [3:0]  ones;
    logic [7:0]  c_hi, c_tens, c_ones;

    qrsd_pkg::fifo_ent_t ent_reg, ent_next;
    logic                ent_valid_reg;

    // First stage: split the value by 100 (numeric) or 45 (alphanumeric)
    // using reciprocal multiplies that are exact over the legal ranges.
    assign prod_num = {6'd0, grp.value[9:0]} * 16'd41;
    assign hi_num   = prod_num[15:12];
    assign rem_num  = grp.value[9:0] - ({6'd0, hi_num} * 10'd100);
    assign prod_al  = {11'd0, grp.value} * 22'd1457;
    assign hi_al    = prod_al[21:16];
    assign rem_al   = grp.value - ({5'd0, hi_al} * 11'd45);

    always_comb
    begin
        split_next.kind   = grp.kind;
        split_next.nchars = grp.nchars;
        split_next.last   = grp.last;
        split_next.status = grp.status;
        split_next.raw    = grp.value[7:0];
        if (grp.kind == qrsd_pkg::GRP_ALNUM)
        begin
            split_next.hi  = hi_al;
            split_next.rem = rem_al[6:0];
        end
        else
        begin
            split_next.hi  = {2'd0, hi_num};
            split_next.rem = rem_num[6:0];
        end
    end

    // Second stage: tens and units of the remainder, then the characters
    assign prod_tens = {8'd0, split_reg.rem} * 15'd205;
    assign tens      = prod_tens[14:11];
    assign ones_full = split_reg.rem - ({3'd0, tens} * 7'd10);
    assign ones      = ones_full[3:0];
    assign c_hi      = qrsd_pkg::ASCII_ZERO + {2'd0, split_reg.hi};
    assign c_tens    = qrsd_pkg::ASCII_ZERO + {4'd0, tens};
    assign c_ones    = qrsd_pkg::ASCII_ZERO + {4'd0, ones};

    always_comb
    begin
        ent_next.nchars = split_reg.nchars;
        ent_next.last   = split_reg.last;
        ent_next.status = split_reg.status;
        ent_next.chars  = '0;
        case (split_reg.kind)
            qrsd_pkg::GRP_NUMERIC:
            begin
                if (split_reg.nchars == 2'd3)
                begin
                    ent_next.chars[0] = c_hi;
                    ent_next.chars[1] = c_tens;
                    ent_next.chars[2] = c_ones;
                end
                else if (split_reg.nchars == 2'd2)
                begin
                    ent_next.chars[0] = c_tens;
                    ent_next.chars[1] = c_ones;
                end
                else
                begin
                    ent_next.chars[0] = c_ones;
                end
            end
            qrsd_pkg::GRP_ALNUM:
            begin
                if (split_reg.nchars == 2'd2)
                begin
                    ent_next.chars[0] = qrsd_pkg::alnum_char(split_reg.hi);
                    ent_next.chars[1] = qrsd_pkg::alnum_char(split_reg.rem[5:0]);
                end
                else
                begin
                    ent_next.chars[0] = qrsd_pkg::alnum_char(split_reg.rem[5:0]);
                end
            end
            default:
            begin
                ent_next.chars[0] = split_reg.raw;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_valid_reg <= 1'b0;
            ent_valid_reg   <= 1'b0;
        end
        else
        begin
            split_valid_reg <= grp_valid;
            ent_valid_reg   <= split_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        split_reg <= split_next;
        ent_reg   <= ent_next;
    end

    assign split_valid = split_valid_reg;
    assign ent_valid   = ent_valid_reg;
    assign ent         = ent_reg;

endmodule

/* sv/qr_segment_data_decoder.sv */
`timescale 1ns / 1ps
// Path: the data bit that completes a group passes through group capture, split, character
// build, then the result queue, before the characters of that group appear at the output.
// Throughput: one data bit per cycle; characters leave an eight-group queue one per cycle
// unless out_stall; input stalls only when that queue and the three pipeline stages could overflow.
// Reset (asynchronous, active low) sets mode numeric, count zero and an empty queue.

module qr_segment_data_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  qrsd_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qrsd_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int CNT_W = qrsd_pkg::PTR_W + 1;

    logic                in_accept;
    logic                cfg_we;
    logic                grp_valid;
    qrsd_pkg::grp_t      grp;
    logic                split_valid;
    logic                ent_valid;
    qrsd_pkg::fifo_ent_t ent;

    qrsd_pkg::fifo_ent_t fifo_mem [qrsd_pkg::FIFO_DEPTH];
    logic [qrsd_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [qrsd_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [1:0]                 idx_reg, idx_next;
    logic [CNT_W:0]             in_flight;
    qrsd_pkg::fifo_ent_t        head;
    logic                       out_accept;
    logic                       head_done;

    // Configuration is taken at once; writes arrive only while idle is a rule for the user, not enforced here
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Hold off input while the queue could not absorb everything in flight
    assign in_flight = {1'b0, count_reg} + {{CNT_W{1'b0}}, grp_valid}
                     + {{CNT_W{1'b0}}, split_valid} + {{CNT_W{1'b0}}, ent_valid};
    assign in_stall  = (in_flight >= (CNT_W + 1)'(qrsd_pkg::FIFO_DEPTH));
    assign in_accept = in_valid && !in_stall;

    qrsd_group u_group (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .item      (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    qrsd_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_valid   (grp_valid),
        .grp         (grp),
        .split_valid (split_valid),
        .ent_valid   (ent_valid),
        .ent         (ent)
    );

    // Output side: walk the characters of the head entry one request at a time
    assign head       = fifo_mem[rd_ptr_reg];
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign head_done  = (idx_reg == (head.nchars - 2'd1));

    always_comb
    begin
        out_item.char_code = head.chars[idx_reg];
        out_item.last      = head_done && head.last;
        out_item.status    = head_done ? head.status : qrsd_pkg::STATUS_OK;
    end

    // Queue pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        if (ent_valid)
        begin
            wr_ptr_next = wr_ptr_reg + {{(qrsd_pkg::PTR_W-1){1'b0}}, 1'b1};
        end
        if (out_accept)
        begin
            if (head_done)
            begin
                idx_next    = 2'd0;
                rd_ptr_next = rd_ptr_reg + {{(qrsd_pkg::PTR_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        count_next = count_reg + {{(CNT_W-1){1'b0}}, ent_valid}
                   - {{(CNT_W-1){1'b0}}, (out_accept && head_done)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (ent_valid)
        begin
            fifo_mem[wr_ptr_reg] <= ent;
        end
    end

endmodule
